>>> rtl/lfk_pkg.sv
package lfk_pkg;

  localparam int CORDIC_W     = 34;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_THIGH = 2'd1;
  localparam logic [1:0] REG_SHANK = 2'd2;

  typedef logic signed [CORDIC_W-1:0] cword_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
     12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
     15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
     18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
     21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
     24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
     27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/lfk_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage.
module lfk_cordic #(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [15:0]                   angle,
  output logic signed [TRIG_FRACTION_BITS:0] sin_q,
  output logic signed [TRIG_FRACTION_BITS:0] cos_q
);
  import lfk_pkg::*;

  localparam int SH = CORDIC_FRAC - TRIG_FRACTION_BITS;
  localparam int N = CORDIC_STEPS;

  cword_t     x_r [N+1];
  cword_t     y_r [N+1];
  cword_t     z_r [N+1];
  logic       f_r [N+1];
  cword_t     xs, ys;

  logic [31:0] a_full;
  logic        flip;
  logic [31:0] a_rot;
  assign a_full = {angle, 16'h0};
  assign flip = a_full[31] ^ a_full[30];
  assign a_rot = flip ? a_full + 32'h80000000 : a_full;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= cword_t'($signed(a_rot));
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][CORDIC_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - cword_t'({2'b00, atan_entry(i)});
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + cword_t'({2'b00, atan_entry(i)});
        end
      end
    end
  end

  assign xs = f_r[N] ? -x_r[N] : x_r[N];
  assign ys = f_r[N] ? -y_r[N] : y_r[N];

  function automatic logic signed [TRIG_FRACTION_BITS:0] to_q(input cword_t v);
    cword_t r;
    r = (v + (cword_t'(1) <<< (SH-1))) >>> SH;
    if (r > cword_t'((1 <<< TRIG_FRACTION_BITS) - 1))
      return {1'b0, {TRIG_FRACTION_BITS{1'b1}}};
    if (r < -cword_t'(1 <<< TRIG_FRACTION_BITS))
      return {1'b1, {TRIG_FRACTION_BITS{1'b0}}};
    return r[TRIG_FRACTION_BITS:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= to_q(ys);
      cos_q <= to_q(xs);
    end
  end
endmodule

>>> rtl/leg_forward_kinematics_3dof.sv
// Channel | Ports                                  | Direction
// in      | in_valid/in_ready, yaw/hip/knee angle  | request in
// out     | out_valid/out_ready, foot_x/y/z        | result out
// cfg     | cfg_we, cfg_index, cfg_data            | register write
//
// One request enters per cycle while the pipe is not stalled. The pipe has 1 angle stage,
// 1 CORDIC load stage, 30 CORDIC stages, 1 trig rounding stage and 4 multiply/round stages.
// rst_n (synchronous, active low) clears the valid bits and the link lengths.
// The whole pipe advances only when the output stage is empty or taken, so a
// stall freezes every stage and nothing is lost or repeated.
module leg_forward_kinematics_3dof #(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_yaw_angle,
  input  logic signed [15:0] in_hip_angle,
  input  logic signed [15:0] in_knee_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] out_foot_x,
  output logic signed [18:0] out_foot_y,
  output logic signed [18:0] out_foot_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lfk_pkg::*;

  localparam int F = TRIG_FRACTION_BITS;
  localparam int LAT = CORDIC_STEPS + 7;
  localparam int PW = 18 + F + 1;   // products l*trig
  localparam int RW = 18 + F + 2;   // reach, sums
  localparam int FW = RW + F + 2;   // reach*trig

  logic [15:0] l0_r, l1_r, l2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_r <= '0; l1_r <= '0; l2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:  l0_r <= cfg_data;
        REG_THIGH: l1_r <= cfg_data;
        REG_SHANK: l2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] v_r;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_valid};
  end

  // Angle stage: register inputs and form hip+knee modulo a full turn.
  logic [15:0] yaw_r, hip_r, sum_r;
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r <= in_yaw_angle;
      hip_r <= in_hip_angle;
      sum_r <= in_hip_angle + in_knee_angle;
    end
  end

  logic signed [F:0] s0, c0, s1, c1, s12, c12;
  lfk_cordic #(.TRIG_FRACTION_BITS(F)) u_yaw (.clk, .en, .angle(yaw_r), .sin_q(s0), .cos_q(c0));
  lfk_cordic #(.TRIG_FRACTION_BITS(F)) u_hip (.clk, .en, .angle(hip_r), .sin_q(s1), .cos_q(c1));
  lfk_cordic #(.TRIG_FRACTION_BITS(F)) u_sum (.clk, .en, .angle(sum_r), .sin_q(s12), .cos_q(c12));

  // Yaw trig is held in s0_r/c0_r and then s0_rr/c0_rr while the products and the reach are formed.
  logic signed [F:0] s0_r, c0_r, s0_rr, c0_rr;
  logic signed [PW-1:0] p1s_r, p2s_r, p1c_r, p2c_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r  <= s0;  c0_r  <= c0;
      p1s_r <= $signed({1'b0, l1_r}) * s1;
      p2s_r <= $signed({1'b0, l2_r}) * s12;
      p1c_r <= $signed({1'b0, l1_r}) * c1;
      p2c_r <= $signed({1'b0, l2_r}) * c12;
    end
  end

  logic signed [RW-1:0] sx_r, reach_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s0_rr   <= s0_r; c0_rr <= c0_r;
      sx_r    <= RW'(p1s_r) + RW'(p2s_r);
      reach_r <= (RW'($signed({1'b0, l0_r})) <<< F) + RW'(p1c_r) + RW'(p2c_r);
    end
  end

  logic signed [FW-1:0] fy_p_r, fz_p_r;
  logic signed [RW-1:0] sx_rr;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_rr  <= sx_r;
      fy_p_r <= FW'(reach_r) * FW'(s0_rr);
      fz_p_r <= FW'(reach_r) * FW'(c0_rr);
    end
  end

  // Round half away from zero; rnd_x also negates its result, and rnd_p negates it when neg is set.
  function automatic logic signed [18:0] rnd_x(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] a;
    a = v[RW-1] ? -v : v;
    a = (a + (RW'(1) <<< (F-1))) >>> F;
    return v[RW-1] ? a[18:0] : -a[18:0];
  endfunction

  function automatic logic signed [18:0] rnd_p(input logic signed [FW-1:0] v,
                                               input logic neg);
    logic signed [FW-1:0] a;
    logic signed [18:0]   q;
    a = v[FW-1] ? -v : v;
    a = (a + (FW'(1) <<< (2*F-1))) >>> (2*F);
    q = a[18:0];
    return (v[FW-1] ^ neg) ? -q : q;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_foot_x <= rnd_x(sx_rr);
      out_foot_y <= rnd_p(fy_p_r, 1'b0);
      out_foot_z <= rnd_p(fz_p_r, 1'b1);
    end
  end
endmodule
